// File: rtl/cdnc_pkg.sv
// Shared types, constants and calendar arithmetic for the calendar day number converter.
`timescale 1ns / 1ps

package cdnc_pkg;

	// Number of register stages from request to result.
	localparam int N_STAGES = 7;

	// Serial day of 31 Dec 65535, the last representable date.
	localparam logic [24:0] MAX_SERIAL = 25'd23936534;
	// Day count of 15 Oct 1582, the first Gregorian day, before the ten gap days are taken out.
	localparam logic [24:0] GAP_SERIAL = 25'd578114;
	localparam logic [24:0] GAP_DAYS   = 25'd10;
	localparam logic [15:0] GAP_YEAR   = 16'd1582;
	localparam logic [3:0]  GAP_MONTH  = 4'd10;
	localparam logic [4:0]  GAP_FIRST  = 5'd5;
	localparam logic [4:0]  GAP_LAST   = 5'd14;
	// Zero-based day of 1582 that follows 4 Oct once the gap is closed up.
	localparam logic [8:0]  GAP_DOY    = 9'd277;
	localparam logic [15:0] YEAR_MAX   = 16'd65535;

	// Century correction applies from this year onwards, counted from this base.
	localparam logic [16:0] GREG_FROM = 17'd1700;
	localparam logic [16:0] GREG_BASE = 17'd1600;

	// floor(2^32 / 365.2425), used for the first year estimate.
	localparam logic [23:0] YEAR_RECIP  = 24'd11759221;
	// ceil(2^27 / 3), exact for dividends below 2^25.
	localparam logic [25:0] THIRD_RECIP = 26'd44739243;
	// Bias that makes a signed quotient non-negative before dividing by three.
	localparam logic [24:0] DIV3_BIAS   = 25'd12582912;
	localparam logic [23:0] DIV3_BIAS_Q = 24'd4194304;
	// ceil(2^17 / 25), exact for dividends below 43690.
	localparam logic [12:0] DIV25_RECIP = 13'd5243;

	typedef enum logic [2:0] {
		OP_TO_SERIAL  = 3'd0,
		OP_TO_DATE    = 3'd1,
		OP_ADD_DAYS   = 3'd2,
		OP_ADD_MONTHS = 3'd3,
		OP_ADD_YEARS  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_MONTH  = 3'd1,
		ST_BAD_DAY    = 3'd2,
		ST_GAP        = 3'd3,
		ST_BAD_SERIAL = 3'd4,
		ST_BAD_YEAR   = 3'd5
	} status_t;

	typedef struct packed {
		logic [24:0] serial;
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		status_t     status;
	} result_t;

	// Quotient by 25 through a reciprocal multiply.
	function automatic logic [9:0] div25(input logic [13:0] z);
		logic [26:0] prod;
		prod = {13'd0, z} * {14'd0, DIV25_RECIP};
		return prod[26:17];
	endfunction

	// Leap year rule: Julian up to 1582, Gregorian after it.
	function automatic logic is_leap(input logic [15:0] y);
		logic [13:0] z4;
		logic [13:0] z16;
		logic [14:0] m4;
		logic [14:0] m16;
		logic        by4;
		logic        by100;
		logic        by400;
		z4    = y[15:2];
		z16   = {2'b00, y[15:4]};
		m4    = {5'd0, div25(z4)} * 15'd25;
		m16   = {5'd0, div25(z16)} * 15'd25;
		by4   = (y[1:0] == 2'b00);
		by100 = by4 && (m4 == {1'b0, z4});
		by400 = (y[3:0] == 4'd0) && (m16 == {1'b0, z16});
		if (y > GAP_YEAR)
			return by400 || (by4 && !by100);
		return by4;
	endfunction

	// Days before 1 Jan of year y, without the 1582 gap.
	function automatic logic [24:0] year_base(input logic [16:0] y);
		logic [16:0] p;
		logic [16:0] w;
		logic [25:0] b;
		p = y - 17'd1;
		w = p - GREG_BASE;
		b = {9'd0, y} * 26'd365 + 26'd1 + {11'd0, p[16:2]};
		if (p >= GREG_FROM)
			b = b - {16'd0, div25(w[15:2])} + {16'd0, div25({2'b00, w[15:4]})};
		if (y == 17'd0)
			b = 26'd0;
		return b[24:0];
	endfunction

	function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

	// Days before the first of month m in a common year.
	function automatic logic [8:0] cum_days(input logic [3:0] m);
		logic [8:0] c;
		unique case (m)
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/cdnc_ser_path.sv
// Serial day to date datapath: day addition, range check, year search and month split.
`timescale 1ns / 1ps

module cdnc_ser_path (
	input  logic                              clk,
	input  logic [cdnc_pkg::N_STAGES-1:0]     en,
	input  logic [2:0]                        operation,
	input  logic [24:0]                       serial_in,
	input  logic signed [24:0]                offset,
	output cdnc_pkg::result_t                 res
);

	// First day of a year from its base, with the gap taken out.
	function automatic logic [24:0] first_day(input logic [24:0] base);
		logic [24:0] f;
		f = base + 25'd1;
		if (f >= cdnc_pkg::GAP_SERIAL)
			f = f - cdnc_pkg::GAP_DAYS;
		return f;
	endfunction

	// Stage 1: target serial, with the day offset added for day arithmetic.
	logic signed [26:0] sum_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (operation == cdnc_pkg::OP_ADD_DAYS)
				sum_s1 <= $signed({2'b00, serial_in}) + 27'(offset);
			else
				sum_s1 <= $signed({2'b00, serial_in});
		end
	end

	// Stage 2: range check and a year estimate by reciprocal multiply.
	logic [48:0] yprod;
	logic        bad_s2;
	logic [24:0] s_s2;
	logic [16:0] e_s2;

	assign yprod = {24'd0, sum_s1[24:0]} * {25'd0, cdnc_pkg::YEAR_RECIP};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			bad_s2 <= (sum_s1 < 27'sd1) || (sum_s1 > $signed({2'b00, cdnc_pkg::MAX_SERIAL}));
			s_s2   <= sum_s1[24:0];
			e_s2   <= yprod[48:32];
		end
	end

	// Stage 3: year bases of the estimate and its two neighbours.
	logic [16:0] cand_m;
	logic [16:0] cand_p;
	logic [24:0] base_m_s3;
	logic [24:0] base_e_s3;
	logic [24:0] base_p_s3;
	logic [16:0] e_s3;
	logic [24:0] s_s3;
	logic        bad_s3;

	assign cand_m = (e_s2 == 17'd0) ? 17'd0 : e_s2 - 17'd1;
	assign cand_p = e_s2 + 17'd1;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			base_m_s3 <= cdnc_pkg::year_base(cand_m);
			base_e_s3 <= cdnc_pkg::year_base(e_s2);
			base_p_s3 <= cdnc_pkg::year_base(cand_p);
			e_s3      <= e_s2;
			s_s3      <= s_s2;
			bad_s3    <= bad_s2;
		end
	end

	// Stage 4: pick the last candidate year that starts on or before the serial.
	logic signed [26:0] dm;
	logic signed [26:0] de;
	logic signed [26:0] dp;
	logic [16:0]        year_c;
	logic [8:0]         doy_c;
	logic [15:0]        year_s4;
	logic [8:0]         doy_s4;
	logic [24:0]        s_s4;
	logic               bad_s4;

	assign dm = $signed({2'b00, s_s3}) - $signed({2'b00, first_day(base_m_s3)});
	assign de = $signed({2'b00, s_s3}) - $signed({2'b00, first_day(base_e_s3)});
	assign dp = $signed({2'b00, s_s3}) - $signed({2'b00, first_day(base_p_s3)});

	always_comb begin
		priority if (!dp[26]) begin
			year_c = e_s3 + 17'd1;
			doy_c  = dp[8:0];
		end else if (!de[26]) begin
			year_c = e_s3;
			doy_c  = de[8:0];
		end else begin
			year_c = (e_s3 == 17'd0) ? 17'd0 : e_s3 - 17'd1;
			doy_c  = dm[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			year_s4 <= year_c[15:0];
			doy_s4  <= doy_c;
			s_s4    <= s_s3;
			bad_s4  <= bad_s3;
		end
	end

	// Stage 5: leap flag of the year and reopening of the 1582 gap.
	logic [15:0] year_s5;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [24:0] s_s5;
	logic        bad_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			year_s5 <= year_s4;
			leap_s5 <= cdnc_pkg::is_leap(year_s4);
			if (year_s4 == cdnc_pkg::GAP_YEAR && doy_s4 >= cdnc_pkg::GAP_DOY)
				doy_s5 <= doy_s4 + cdnc_pkg::GAP_DAYS[8:0];
			else
				doy_s5 <= doy_s4;
			s_s5   <= s_s4;
			bad_s5 <= bad_s4;
		end
	end

	// Stage 6: month search over the cumulative month table.
	logic [3:0]  mo_c;
	logic [8:0]  start_c;
	logic [3:0]  mo_s6;
	logic [8:0]  start_s6;
	logic [8:0]  doy_s6;
	logic [15:0] year_s6;
	logic [24:0] s_s6;
	logic        bad_s6;

	always_comb begin
		logic [8:0] cl;
		mo_c    = 4'd1;
		start_c = 9'd0;
		for (int k = 2; k <= 12; k++) begin
			cl = cdnc_pkg::cum_days(4'(k)) + ((leap_s5 && k > 2) ? 9'd1 : 9'd0);
			if (cl <= doy_s5) begin
				mo_c    = 4'(k);
				start_c = cl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			mo_s6    <= mo_c;
			start_s6 <= start_c;
			doy_s6   <= doy_s5;
			year_s6  <= year_s5;
			s_s6     <= s_s5;
			bad_s6   <= bad_s5;
		end
	end

	// Stage 7: day of month and the final result.
	logic [8:0] day_c;

	assign day_c = doy_s6 - start_s6 + 9'd1;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			if (bad_s6) begin
				res.serial <= '0;
				res.year   <= '0;
				res.month  <= '0;
				res.day    <= '0;
				res.status <= cdnc_pkg::ST_BAD_SERIAL;
			end else begin
				res.serial <= s_s6;
				res.year   <= year_s6;
				res.month  <= mo_s6;
				res.day    <= day_c[4:0];
				res.status <= cdnc_pkg::ST_OK;
			end
		end
	end

endmodule

// File: rtl/cdnc_date_path.sv
// Date datapath: date checks, month and year carry, and date to serial day.
`timescale 1ns / 1ps

module cdnc_date_path (
	input  logic                              clk,
	input  logic [cdnc_pkg::N_STAGES-1:0]     en,
	input  logic [2:0]                        operation,
	input  logic [15:0]                       year_in,
	input  logic [3:0]                        month_in,
	input  logic [4:0]                        day_in,
	input  logic                              last_of_month,
	input  logic signed [24:0]                offset,
	output cdnc_pkg::result_t                 res
);

	// Stage 1: month index plus offset, its quarter biased for division by three.
	logic signed [25:0] t_c;
	logic signed [23:0] u_c;
	logic [2:0]         op_s1;
	logic [15:0]        y_s1;
	logic [3:0]         m_s1;
	logic [4:0]         d_s1;
	logic               last_s1;
	logic signed [24:0] off_s1;
	logic signed [25:0] t_s1;
	logic [24:0]        v_s1;
	logic               leap_s1;

	assign t_c = $signed({22'd0, month_in}) - 26'sd1 + 26'(offset);
	assign u_c = t_c[25:2];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1   <= operation;
			y_s1    <= year_in;
			m_s1    <= month_in;
			d_s1    <= day_in;
			last_s1 <= last_of_month;
			off_s1  <= offset;
			t_s1    <= t_c;
			v_s1    <= 25'(u_c) + cdnc_pkg::DIV3_BIAS;
			leap_s1 <= cdnc_pkg::is_leap(year_in);
		end
	end

	// Stage 2: floor quotient of the month index by twelve, and the input date check.
	logic [50:0]        qprod;
	logic [23:0]        qd;
	logic [4:0]         len1;
	logic [4:0]         dres1;
	cdnc_pkg::status_t  st1_c;
	logic [2:0]         op_s2;
	logic [15:0]        y_s2;
	logic [3:0]         m_s2;
	logic [4:0]         d_s2;
	logic               last_s2;
	logic signed [24:0] off_s2;
	logic signed [25:0] t_s2;
	logic signed [23:0] q_s2;
	cdnc_pkg::status_t  st_s2;

	assign qprod = {26'd0, v_s1} * {25'd0, cdnc_pkg::THIRD_RECIP};
	assign qd    = qprod[50:27];
	assign len1  = cdnc_pkg::month_len(leap_s1, m_s1);
	assign dres1 = last_s1 ? len1 : d_s1;

	always_comb begin
		priority if (m_s1 < 4'd1 || m_s1 > 4'd12)
			st1_c = cdnc_pkg::ST_BAD_MONTH;
		else if (dres1 == 5'd0 || dres1 > len1)
			st1_c = cdnc_pkg::ST_BAD_DAY;
		else if (y_s1 == cdnc_pkg::GAP_YEAR && m_s1 == cdnc_pkg::GAP_MONTH &&
				dres1 >= cdnc_pkg::GAP_FIRST && dres1 <= cdnc_pkg::GAP_LAST)
			st1_c = cdnc_pkg::ST_GAP;
		else
			st1_c = cdnc_pkg::ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			op_s2   <= op_s1;
			y_s2    <= y_s1;
			m_s2    <= m_s1;
			d_s2    <= d_s1;
			last_s2 <= last_s1;
			off_s2  <= off_s1;
			t_s2    <= t_s1;
			q_s2    <= $signed(qd - cdnc_pkg::DIV3_BIAS_Q);
			st_s2   <= st1_c;
		end
	end

	// Stage 3: new month and year, and the year range check.
	logic signed [25:0] q26;
	logic signed [25:0] rem_c;
	logic signed [26:0] ny_c;
	logic               is_months;
	logic               is_years;
	logic [15:0]        ny_s3;
	logic [3:0]         nm_s3;
	logic [4:0]         d_s3;
	logic               last_s3;
	cdnc_pkg::status_t  st_s3;

	assign is_months = (op_s2 == cdnc_pkg::OP_ADD_MONTHS);
	assign is_years  = (op_s2 == cdnc_pkg::OP_ADD_YEARS);
	assign q26       = 26'(q_s2);
	assign rem_c     = t_s2 - (q26 <<< 3) - (q26 <<< 2);

	always_comb begin
		if (is_months)
			ny_c = $signed({11'd0, y_s2}) + 27'(q_s2);
		else if (is_years)
			ny_c = $signed({11'd0, y_s2}) + 27'(off_s2);
		else
			ny_c = $signed({11'd0, y_s2});
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ny_s3   <= ny_c[15:0];
			nm_s3   <= is_months ? rem_c[3:0] + 4'd1 : m_s2;
			d_s3    <= d_s2;
			last_s3 <= last_s2;
			if (st_s2 != cdnc_pkg::ST_OK)
				st_s3 <= st_s2;
			else if ((is_months || is_years) &&
					(ny_c < 27'sd0 || ny_c > $signed({11'd0, cdnc_pkg::YEAR_MAX})))
				st_s3 <= cdnc_pkg::ST_BAD_YEAR;
			else
				st_s3 <= cdnc_pkg::ST_OK;
		end
	end

	// Stage 4: leap flag and day base of the resulting year.
	logic              leap_s4;
	logic [24:0]       base_s4;
	logic [15:0]       ny_s4;
	logic [3:0]        nm_s4;
	logic [4:0]        d_s4;
	logic              last_s4;
	cdnc_pkg::status_t st_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			leap_s4 <= cdnc_pkg::is_leap(ny_s3);
			base_s4 <= cdnc_pkg::year_base({1'b0, ny_s3});
			ny_s4   <= ny_s3;
			nm_s4   <= nm_s3;
			d_s4    <= d_s3;
			last_s4 <= last_s3;
			st_s4   <= st_s3;
		end
	end

	// Stage 5: check of the moved date and its serial before the gap.
	logic [4:0]        len2;
	logic [4:0]        dres2;
	logic [24:0]       sum_s5;
	logic [15:0]       ny_s5;
	logic [3:0]        nm_s5;
	logic [4:0]        dres_s5;
	cdnc_pkg::status_t st_s5;

	assign len2  = cdnc_pkg::month_len(leap_s4, nm_s4);
	assign dres2 = last_s4 ? len2 : d_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sum_s5  <= base_s4 + {16'd0, cdnc_pkg::cum_days(nm_s4)}
				+ {24'd0, (leap_s4 && nm_s4 > 4'd2)} + {20'd0, dres2};
			ny_s5   <= ny_s4;
			nm_s5   <= nm_s4;
			dres_s5 <= dres2;
			priority if (st_s4 != cdnc_pkg::ST_OK)
				st_s5 <= st_s4;
			else if (dres2 == 5'd0 || dres2 > len2)
				st_s5 <= cdnc_pkg::ST_BAD_DAY;
			else if (ny_s4 == cdnc_pkg::GAP_YEAR && nm_s4 == cdnc_pkg::GAP_MONTH &&
					dres2 >= cdnc_pkg::GAP_FIRST && dres2 <= cdnc_pkg::GAP_LAST)
				st_s5 <= cdnc_pkg::ST_GAP;
			else
				st_s5 <= cdnc_pkg::ST_OK;
		end
	end

	// Stage 6: remove the ten skipped days after the calendar switch.
	logic [24:0]       ser_s6;
	logic [15:0]       ny_s6;
	logic [3:0]        nm_s6;
	logic [4:0]        dres_s6;
	cdnc_pkg::status_t st_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			if (sum_s5 >= cdnc_pkg::GAP_SERIAL)
				ser_s6 <= sum_s5 - cdnc_pkg::GAP_DAYS;
			else
				ser_s6 <= sum_s5;
			ny_s6   <= ny_s5;
			nm_s6   <= nm_s5;
			dres_s6 <= dres_s5;
			st_s6   <= st_s5;
		end
	end

	// Stage 7: final result, cleared when a check failed.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			res.status <= st_s6;
			if (st_s6 != cdnc_pkg::ST_OK) begin
				res.serial <= '0;
				res.year   <= '0;
				res.month  <= '0;
				res.day    <= '0;
			end else begin
				res.serial <= ser_s6;
				res.year   <= ny_s6;
				res.month  <= nm_s6;
				res.day    <= dres_s6;
			end
		end
	end

endmodule

// File: rtl/calendar_day_number_converter.sv
// Top level of the calendar day number converter: pipeline control and result select.
//
//  Channel | Valid     | Stall     | Payload
//  --------+-----------+-----------+----------------------------------------------------
//  request | req_valid | req_stall | operation, year_in, month_in, day_in,
//          |           |           | last_of_month, serial_in, offset
//  result  | res_valid | res_stall | serial_out, year_out, month_out, day_out, status
//
// One item enters per cycle while req_stall is low, and each result passes the seven
// register stages of the two datapaths.
// Reset clears only the stage valid bits and the path select bits that travel with them;
// the datapath registers hold no reset value.
// A stalled result holds the last stage; bubbles in earlier stages still close up, so
// req_stall rises only when all seven stages hold an item and the result is stalled.
`timescale 1ns / 1ps

module calendar_day_number_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         operation,
	input  logic [15:0]        year_in,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	input  logic               last_of_month,
	input  logic [24:0]        serial_in,
	input  logic signed [24:0] offset,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [24:0]        serial_out,
	output logic [15:0]        year_out,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [2:0]         status
);

	localparam int NS = cdnc_pkg::N_STAGES;

	logic [NS-1:0]     vld_q;
	logic [NS-1:0]     ser_q;
	logic [NS-1:0]     rdy;
	logic              is_ser;
	cdnc_pkg::result_t ser_res;
	cdnc_pkg::result_t date_res;
	cdnc_pkg::result_t res;

	// A stage may load when it is empty or its item moves on in the same cycle.
	always_comb begin
		rdy[NS-1] = !vld_q[NS-1] || !res_stall;
		for (int k = NS - 2; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign req_stall = !rdy[0];
	assign is_ser    = (operation == cdnc_pkg::OP_TO_DATE) ||
		(operation == cdnc_pkg::OP_ADD_DAYS);

	// Valid bits and the datapath choice travel with each item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ser_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= req_valid;
				ser_q[0] <= is_ser;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
					ser_q[k] <= ser_q[k-1];
				end
			end
		end
	end

	cdnc_ser_path u_ser_path (
		.clk       (clk),
		.en        (rdy),
		.operation (operation),
		.serial_in (serial_in),
		.offset    (offset),
		.res       (ser_res)
	);

	cdnc_date_path u_date_path (
		.clk           (clk),
		.en            (rdy),
		.operation     (operation),
		.year_in       (year_in),
		.month_in      (month_in),
		.day_in        (day_in),
		.last_of_month (last_of_month),
		.offset        (offset),
		.res           (date_res)
	);

	// Result of the datapath that served the item in the last stage.
	assign res        = ser_q[NS-1] ? ser_res : date_res;
	assign res_valid  = vld_q[NS-1];
	assign serial_out = res.serial;
	assign year_out   = res.year;
	assign month_out  = res.month;
	assign day_out    = res.day;
	assign status     = res.status;

	// A failed check leaves every date field at zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != cdnc_pkg::ST_OK |->
			serial_out == 25'd0 && year_out == 16'd0 && month_out == 4'd0 && day_out == 5'd0)
		else $error("error result carries a non-zero date");

	// A good result names a real month and day.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == cdnc_pkg::ST_OK |->
			month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 && day_out <= 5'd31)
		else $error("good result with month or day out of range");

	// A good result lies within the serial range.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == cdnc_pkg::ST_OK |->
			serial_out != 25'd0 && serial_out <= cdnc_pkg::MAX_SERIAL)
		else $error("good result with serial out of range");

	// Requests are held back only when every stage is full and the result is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (&vld_q) && res_stall)
		else $error("request stalled while the pipeline has room");

endmodule

// File: verif/tb_calendar_day_number_converter.sv
// Self-checking testbench for the calendar day number converter.
`timescale 1ns / 1ps

module tb_calendar_day_number_converter;

	// One request and its expected result.
	typedef struct {
		logic [2:0]         op;
		logic [15:0]        y;
		logic [3:0]         m;
		logic [4:0]         d;
		logic               lst;
		logic [24:0]        ser;
		logic signed [24:0] off;
	} request_t;

	typedef struct {
		logic [24:0] ser;
		logic [15:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		logic [2:0]  st;
	} date_result_t;

	typedef struct {
		request_t     rq;
		logic         known;
		date_result_t exp;
	} table_row_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [2:0]         operation;
	logic [15:0]        year_in;
	logic [3:0]         month_in;
	logic [4:0]         day_in;
	logic               last_of_month;
	logic [24:0]        serial_in;
	logic signed [24:0] offset;
	logic               res_valid;
	logic               res_stall;
	logic [24:0]        serial_out;
	logic [15:0]        year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;
	logic [2:0]         status;

	date_result_t expected_dates[$];
	int           mismatch_count;
	int           results_seen;
	int           items_sent;
	int           idle_cycles;
	bit           quiet_tail;
	bit           long_hold;
	bit           drive_done;

	calendar_day_number_converter i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.operation(operation), .year_in(year_in), .month_in(month_in),
		.day_in(day_in), .last_of_month(last_of_month),
		.serial_in(serial_in), .offset(offset),
		.res_valid(res_valid), .res_stall(res_stall),
		.serial_out(serial_out), .year_out(year_out), .month_out(month_out),
		.day_out(day_out), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Calendar arithmetic for the predictor.
	function automatic bit leap(longint y);
		if (y > 1582) begin
			if (y % 400 == 0) return 1'b1;
			if (y % 100 == 0) return 1'b0;
		end
		return (y % 4) == 0;
	endfunction

	function automatic longint days_in_month(longint y, longint m);
		longint tbl[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m == 2 && leap(y)) return 29;
		return tbl[m - 1];
	endfunction

	function automatic longint day_number(longint y, longint m, longint d);
		longint s;
		longint p;
		s = 0;
		if (y > 0) begin
			p = y - 1;
			s = 365 * y + 1 + p / 4;
			if (p >= 1700) s = s - (p - 1600) / 100 + (p - 1600) / 400;
		end
		for (int i = 1; i < m; i++) s += days_in_month(1, i);
		if (m > 2 && leap(y)) s++;
		s += d;
		if (s >= 578114) s -= 10;
		return s;
	endfunction

	// Validates a date and resolves the last-day flag.
	function automatic logic [2:0] date_status(longint y, longint m, longint d, bit lst,
			output longint dres);
		longint len;
		dres = 0;
		if (m < 1 || m > 12) return cdnc_pkg::ST_BAD_MONTH;
		len = days_in_month(y, m);
		if (lst) d = len;
		if (d == 0 || d > len) return cdnc_pkg::ST_BAD_DAY;
		if (y == 1582 && m == 10 && d >= 5 && d <= 14) return cdnc_pkg::ST_GAP;
		dres = d;
		return cdnc_pkg::ST_OK;
	endfunction

	function automatic date_result_t convert_date(request_t rq);
		date_result_t r;
		longint s, y, m, d, dr, t, q, lo, hi, mid, mx;
		logic [2:0] st;
		r = '{default: '0};
		mx = day_number(65535, 12, 31);
		if (rq.op == cdnc_pkg::OP_TO_DATE || rq.op == cdnc_pkg::OP_ADD_DAYS) begin
			s = rq.ser;
			if (rq.op == cdnc_pkg::OP_ADD_DAYS) s += rq.off;
			if (s < 1 || s > mx) begin
				r.st = cdnc_pkg::ST_BAD_SERIAL;
				return r;
			end
			lo = 0;
			hi = 65535;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (day_number(mid, 1, 1) <= s) lo = mid; else hi = mid - 1;
			end
			m = 1;
			while (m < 12 && day_number(lo, m + 1, 1) <= s) m++;
			d = s - day_number(lo, m, 1) + 1;
			if (lo == 1582 && m == 10 && d >= 5) d += 10;
			r.ser = 25'(s);
			r.y = 16'(lo);
			r.m = 4'(m);
			r.d = 5'(d);
			r.st = cdnc_pkg::ST_OK;
			return r;
		end
		y = rq.y;
		m = rq.m;
		st = date_status(y, m, rq.d, rq.lst, dr);
		if (st == cdnc_pkg::ST_OK &&
				(rq.op == cdnc_pkg::OP_ADD_MONTHS || rq.op == cdnc_pkg::OP_ADD_YEARS)) begin
			if (rq.op == cdnc_pkg::OP_ADD_MONTHS) begin
				t = m - 1 + rq.off;
				q = (t >= 0) ? t / 12 : -((-t + 11) / 12);
				y += q;
				m = t - q * 12 + 1;
			end else begin
				y += rq.off;
			end
			if (y < 0 || y > 65535) st = cdnc_pkg::ST_BAD_YEAR;
			else st = date_status(y, m, rq.d, rq.lst, dr);
		end
		if (st != cdnc_pkg::ST_OK) begin
			r.st = st;
			return r;
		end
		r.ser = 25'(day_number(y, m, dr));
		r.y = 16'(y);
		r.m = 4'(m);
		r.d = 5'(dr);
		r.st = cdnc_pkg::ST_OK;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Offers one item, after an optional random pause, waits for its acceptance and queues its expected result.
	task automatic send_item(request_t rq, date_result_t want, bit pace);
		int gap;
		if (pace && !quiet_tail && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= rq.op;
		year_in <= rq.y;
		month_in <= rq.m;
		day_in <= rq.d;
		last_of_month <= rq.lst;
		serial_in <= rq.ser;
		offset <= rq.off;
		do @(posedge clk); while (req_stall);
		expected_dates.push_back(want);
		items_sent++;
		@(negedge clk);
	endtask

	// Random item, mostly valid dates and in-range serials.
	function automatic request_t random_item();
		request_t rq;
		int k;
		rq.op = 3'($urandom_range(0, 7));
		rq.y = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($urandom_range(1500, 1700));
		if ($urandom_range(0, 9) == 0) rq.y = 16'd1582;
		rq.m = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
		rq.d = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
		rq.lst = ($urandom_range(0, 4) == 0);
		rq.ser = ($urandom_range(0, 7) == 0) ? 25'($urandom) :
			25'($urandom_range(1, 23936534));
		if ($urandom_range(0, 5) == 0) rq.ser = 25'($urandom_range(577000, 579000));
		k = $urandom_range(0, 3);
		case (k)
			0: rq.off = 25'($urandom);
			1: rq.off = 25'($signed($urandom_range(0, 200)) - 100);
			2: rq.off = 25'($signed($urandom_range(0, 2000000)) - 1000000);
			default: rq.off = 25'($signed($urandom_range(0, 140000)) - 70000);
		endcase
		return rq;
	endfunction

	// Sender: directed table, then random items with a drain pause and a flooding burst.
	initial begin
		table_row_t   rows[$];
		request_t     rq;
		table_row_t   row;
		date_result_t want;
		mismatch_count = 0;
		items_sent = 0;
		quiet_tail = 1'b0;
		long_hold = 1'b0;
		drive_done = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		operation = '0;
		year_in = '0;
		month_in = '0;
		day_in = '0;
		last_of_month = 1'b0;
		serial_in = '0;
		offset = '0;

		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 0, 1, 1, 0, 0, 0}, 1,
			'{1, 0, 1, 1, cdnc_pkg::ST_OK}});
		rows.push_back('{'{cdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 1, 0}, 1,
			'{1, 0, 1, 1, cdnc_pkg::ST_OK}});
		rows.push_back('{'{cdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_SERIAL}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 65535, 12, 31, 0, 0, 0}, 1,
			'{23936534, 65535, 12, 31, cdnc_pkg::ST_OK}});
		rows.push_back('{'{cdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 23936534, 0}, 1,
			'{23936534, 65535, 12, 31, cdnc_pkg::ST_OK}});
		rows.push_back('{'{cdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 23936535, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_SERIAL}});
		rows.push_back('{'{cdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 25'h1FFFFFF, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_SERIAL}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 2000, 0, 1, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_MONTH}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 2000, 15, 1, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_MONTH}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 2000, 3, 0, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_DAY}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1900, 2, 29, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_DAY}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1582, 10, 5, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_GAP}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1582, 10, 14, 0, 0, 0}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_GAP}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1582, 10, 4, 0, 0, 0}, 0, '{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1582, 10, 15, 0, 0, 0}, 0, '{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_TO_SERIAL, 1600, 2, 31, 1, 0, 0}, 0, '{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_DAYS, 0, 0, 0, 0, 1, -1}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_SERIAL}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_DAYS, 0, 0, 0, 0, 25'h1FFFFFF, 25'h1000000}, 0,
			'{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_DAYS, 0, 0, 0, 0, 578100, 20}, 0, '{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_MONTHS, 2000, 1, 31, 1, 0, 1}, 0, '{default: '0}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_MONTHS, 2000, 1, 31, 0, 0, 1}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_DAY}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_MONTHS, 0, 1, 1, 0, 0, -1}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_YEAR}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_MONTHS, 1582, 9, 10, 0, 0, 1}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_GAP}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_YEARS, 65535, 6, 1, 0, 0, 1}, 1,
			'{0, 0, 0, 0, cdnc_pkg::ST_BAD_YEAR}});
		rows.push_back('{'{cdnc_pkg::OP_ADD_YEARS, 2004, 2, 29, 1, 0, -4}, 0, '{default: '0}});
		rows.push_back('{'{3'd7, 2024, 7, 4, 0, 0, 0}, 0, '{default: '0}});

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows: typed expectations where given, the predictor elsewhere.
		foreach (rows[i]) begin
			row = rows[i];
			if (row.known)
				want = row.exp;
			else
				want = convert_date(row.rq);
			send_item(row.rq, want, 1'b0);
		end

		for (int n = 0; n < 1700; n++) begin
			if (n == 500) begin
				// Sender pause until the pipeline has drained.
				req_valid <= 1'b0;
				while (expected_dates.size() != 0) @(negedge clk);
			end
			if (n == 800) long_hold = 1'b1;
			if (n == 1400) quiet_tail = 1'b1;
			rq = random_item();
			send_item(rq, convert_date(rq), 1'b1);
		end
		req_valid <= 1'b0;
		drive_done = 1'b1;
	end

	// Receiver: random stall bursts, one long hold-off, none in the tail.
	initial begin
		int burst;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				res_stall <= 1'b1;
				repeat (60) @(negedge clk);
				res_stall <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				res_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Result checking at the rising edge.
	initial begin
		date_result_t want;
		results_seen = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall) begin
				results_seen++;
				if (expected_dates.size() == 0) begin
					report_mismatch("results taken against items sent", results_seen,
						items_sent);
				end else begin
					want = expected_dates.pop_front();
					if (serial_out !== want.ser) report_mismatch("serial_out", serial_out, want.ser);
					if (year_out !== want.y) report_mismatch("year_out", year_out, want.y);
					if (month_out !== want.m) report_mismatch("month_out", month_out, want.m);
					if (day_out !== want.d) report_mismatch("day_out", day_out, want.d);
					if (status !== want.st) report_mismatch("status", status, want.st);
				end
			end
		end
	end

	// Watchdog and end of run.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
				$display("calendar_day_number_converter: mismatch");
				$finish;
			end
			if (drive_done && expected_dates.size() == 0) begin
				repeat (2 * cdnc_pkg::N_STAGES) @(posedge clk);
				$display("Ran %0d items through all five operations, with stalls and drains;",
					items_sent);
				$display("%0d results checked, %0d errors.", results_seen, mismatch_count);
				if (mismatch_count == 0) begin
					$display("calendar_day_number_converter: match");
				end else begin
					$display("calendar_day_number_converter: mismatch");
				end
				$finish;
			end
		end
	end

endmodule

// File: calendar_day_number_converter.f
rtl/cdnc_pkg.sv
rtl/cdnc_ser_path.sv
rtl/cdnc_date_path.sv
rtl/calendar_day_number_converter.sv
verif/tb_calendar_day_number_converter.sv
